// ===== rtl/core/segscan_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and the glyph table of the seven-segment scan serializer.
// Depends on nothing; every other file refers to it by scoped names.
package segscan_pkg;

   // Digit storage and default scan length
   localparam int STORE_DIGITS        = 4;
   localparam int DIGIT_COUNT_DEFAULT = 4;
   localparam int DIGIT_IDX_W         = $clog2(STORE_DIGITS);

   // Field widths
   localparam int MODE_W    = 3;
   localparam int CODE_W    = 8;
   localparam int PATTERN_W = 8;
   localparam int SELECT_W  = 4;
   localparam int SERIAL_W  = 16;
   localparam int CSR_IDX_W = 1;

   // Glyph codes with a fixed meaning
   localparam int                GLYPH_COUNT = 24;
   localparam logic [CODE_W-1:0] BLANK_CODE  = 8'd255;
   localparam logic [CODE_W-1:0] CODE_E      = 8'd12;
   localparam logic [CODE_W-1:0] CODE_R      = 8'd20;
   localparam logic [CODE_W-1:0] CODE_DASH   = 8'd21;

   // "Err " text, digit 0 in the low byte
   localparam logic [STORE_DIGITS-1:0][CODE_W-1:0] ERR_TEXT =
      {BLANK_CODE, CODE_R, CODE_R, CODE_E};

   // Reset values of the configuration registers
   localparam logic [PATTERN_W-1:0] BLANK_PATTERN_RESET = 8'd255;
   localparam logic [PATTERN_W-1:0] DOT_MASK_RESET      = 8'd127;

   // Select nibble of digit 0; digit i gets this shifted right by i
   localparam logic [SELECT_W-1:0] SELECT_FIRST = 4'b1000;

   // Active-low segment patterns, bit 7 is the dot
   localparam logic [PATTERN_W-1:0] GLYPH_ROM [GLYPH_COUNT] = '{
      8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90,
      8'h88, 8'hC6, 8'h86, 8'h8E, 8'hC2, 8'h89, 8'hF1, 8'hC7, 8'hA3, 8'h8C,
      8'hAF, 8'hBF, 8'hF7, 8'h9C
   };

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLANK_PATTERN = 1'b0,
      CSR_DOT_MASK      = 1'b1
   } csr_index_type;

   // Request modes; codes 6 and 7 are ignored
   typedef enum logic [MODE_W-1:0] {
      MODE_TICK      = 3'd0,
      MODE_SET_CODES = 3'd1,
      MODE_SET_DOTS  = 3'd2,
      MODE_CLEAR     = 3'd3,
      MODE_ERROR     = 3'd4,
      MODE_DASH      = 3'd5
   } mode_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SEND
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic write_state;  // apply the accepted write transaction
      logic start_scan;   // rewind the digit index
      logic load_out;     // fill the result register, advance the index
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_last;     // result register holds the final digit of the scan
   } status_type;

   // Look up a code; anything outside the table shows the blank pattern
   function automatic logic [PATTERN_W-1:0] glyph_lookup(
      input logic [CODE_W-1:0]    code,
      input logic [PATTERN_W-1:0] blank
   );
      logic [PATTERN_W-1:0] pat;
      pat = blank;
      if (code < CODE_W'(GLYPH_COUNT)) begin
         pat = GLYPH_ROM[code[4:0]];
      end
      return pat;
   endfunction

endpackage

// ===== rtl/core/segscan_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: request, result and register write.
// Depends on segscan_pkg for field widths.
interface segscan_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [segscan_pkg::MODE_W-1:0]         mode;
   logic [segscan_pkg::CODE_W-1:0]         code_d0;
   logic [segscan_pkg::CODE_W-1:0]         code_d1;
   logic [segscan_pkg::CODE_W-1:0]         code_d2;
   logic [segscan_pkg::CODE_W-1:0]         code_d3;
   logic                                   dot_d0;
   logic                                   dot_d1;
   logic                                   dot_d2;
   logic                                   dot_d3;

   modport source (
      output valid, mode, code_d0, code_d1, code_d2, code_d3,
             dot_d0, dot_d1, dot_d2, dot_d3,
      input  ready
   );
   modport sink (
      input  valid, mode, code_d0, code_d1, code_d2, code_d3,
             dot_d0, dot_d1, dot_d2, dot_d3,
      output ready
   );
endinterface

interface segscan_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [segscan_pkg::PATTERN_W-1:0]      segment_pattern;
   logic [segscan_pkg::SELECT_W-1:0]       digit_select;
   logic [segscan_pkg::SERIAL_W-1:0]       serial_word;
   logic                                   last_of_scan;

   modport source (
      output valid, segment_pattern, digit_select, serial_word, last_of_scan,
      input  ready
   );
   modport sink (
      input  valid, segment_pattern, digit_select, serial_word, last_of_scan,
      output ready
   );
endinterface

interface segscan_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [segscan_pkg::CSR_IDX_W-1:0]      index;
   logic [segscan_pkg::PATTERN_W-1:0]      data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

// ===== rtl/core/segscan_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences write and scan transactions and drives the handshakes.
// Depends on segscan_pkg for states, modes, commands and status.
module segscan_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic [segscan_pkg::MODE_W-1:0] req_mode,
   output logic                           req_ready,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output segscan_pkg::cmd_type           cmd,
   input  segscan_pkg::status_type        status
);

   segscan_pkg::state_type state_ff;
   segscan_pkg::state_type state_in;
   logic                   req_is_tick;

   assign req_is_tick = (segscan_pkg::mode_type'(req_mode) == segscan_pkg::MODE_TICK);

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= segscan_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         segscan_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_is_tick) begin
                  cmd.start_scan = 1'b1;
                  state_in       = segscan_pkg::ST_LOAD;
               end else begin
                  cmd.write_state = 1'b1;
               end
            end
         end
         segscan_pkg::ST_LOAD: begin
            cmd.load_out = 1'b1;
            state_in     = segscan_pkg::ST_SEND;
         end
         segscan_pkg::ST_SEND: begin
            rsp_valid = 1'b1;
            // Drop back to idle after the last digit, else refill at once
            if (rsp_ready) begin
               if (status.out_last) begin
                  state_in = segscan_pkg::ST_IDLE;
               end else begin
                  cmd.load_out = 1'b1;
               end
            end
         end
         default: begin
            state_in = segscan_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/segscan_dp.sv =====
`timescale 1ns / 1ps
// Datapath: digit codes, dot flags, configuration registers and result register.
// Depends on segscan_pkg; commanded by segscan_ctrl.
module segscan_dp #(
   parameter int SCAN_LEN = segscan_pkg::DIGIT_COUNT_DEFAULT
) (
   input  logic                                                        clock,
   input  logic                                                        reset,
   input  segscan_pkg::cmd_type                                        cmd,
   output segscan_pkg::status_type                                     status,
   input  logic [segscan_pkg::MODE_W-1:0]                              req_mode,
   input  logic [segscan_pkg::STORE_DIGITS-1:0][segscan_pkg::CODE_W-1:0] req_codes,
   input  logic [segscan_pkg::STORE_DIGITS-1:0]                        req_dots,
   input  logic                                                        csr_write,
   input  logic [segscan_pkg::CSR_IDX_W-1:0]                           csr_index,
   input  logic [segscan_pkg::PATTERN_W-1:0]                           csr_data,
   output logic [segscan_pkg::PATTERN_W-1:0]                           segment_pattern,
   output logic [segscan_pkg::SELECT_W-1:0]                            digit_select,
   output logic [segscan_pkg::SERIAL_W-1:0]                            serial_word,
   output logic                                                        last_of_scan
);

   localparam int ND  = segscan_pkg::STORE_DIGITS;
   localparam int CW  = segscan_pkg::CODE_W;
   localparam int PW  = segscan_pkg::PATTERN_W;
   localparam int SW  = segscan_pkg::SELECT_W;
   localparam int IW  = segscan_pkg::DIGIT_IDX_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(SCAN_LEN - 1);

   logic [ND-1:0][CW-1:0] codes_ff;
   logic [ND-1:0][CW-1:0] codes_in;
   logic [ND-1:0]         dots_ff;
   logic [ND-1:0]         dots_in;
   logic [PW-1:0]         blank_ff;
   logic [PW-1:0]         mask_ff;
   logic [IW-1:0]         idx_ff;
   logic [PW-1:0]         pattern_ff;
   logic [PW-1:0]         pattern_in;
   logic [SW-1:0]         select_ff;
   logic                  last_ff;

   // Decode write transactions into new digit state
   always_comb begin
      codes_in = codes_ff;
      dots_in  = dots_ff;
      if (cmd.write_state) begin
         case (segscan_pkg::mode_type'(req_mode))
            segscan_pkg::MODE_SET_CODES: codes_in = req_codes;
            segscan_pkg::MODE_SET_DOTS:  dots_in  = req_dots;
            segscan_pkg::MODE_CLEAR: begin
               codes_in = {ND{segscan_pkg::BLANK_CODE}};
               dots_in  = '0;
            end
            segscan_pkg::MODE_ERROR:     codes_in = segscan_pkg::ERR_TEXT;
            segscan_pkg::MODE_DASH:      codes_in = {ND{segscan_pkg::CODE_DASH}};
            default: begin
            end
         endcase
      end
   end

   // Hold digit state; digits past the scan length keep their reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff <= {ND{segscan_pkg::BLANK_CODE}};
         dots_ff  <= '0;
      end else begin
         for (int i = 0; i < ND; i++) begin
            if (i < SCAN_LEN) begin
               codes_ff[i] <= codes_in[i];
               dots_ff[i]  <= dots_in[i];
            end
         end
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         blank_ff <= segscan_pkg::BLANK_PATTERN_RESET;
         mask_ff  <= segscan_pkg::DOT_MASK_RESET;
      end else if (csr_write) begin
         case (segscan_pkg::csr_index_type'(csr_index))
            segscan_pkg::CSR_BLANK_PATTERN: blank_ff <= csr_data;
            segscan_pkg::CSR_DOT_MASK:      mask_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Pattern of the digit under the scan index
   always_comb begin
      pattern_in = segscan_pkg::glyph_lookup(codes_ff[idx_ff], blank_ff);
      if (dots_ff[idx_ff]) begin
         pattern_in = pattern_in & mask_ff;
      end
   end

   // Scan index and last flag
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         last_ff <= 1'b0;
      end else if (cmd.start_scan) begin
         idx_ff  <= '0;
      end else if (cmd.load_out) begin
         idx_ff  <= idx_ff + IW'(1);
         last_ff <= (idx_ff == LAST_IDX);
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         pattern_ff <= pattern_in;
         select_ff  <= segscan_pkg::SELECT_FIRST >> idx_ff;
      end
   end

   assign status.out_last = last_ff;
   assign segment_pattern = pattern_ff;
   assign digit_select    = select_ff;
   assign serial_word     = {pattern_ff, (PW - SW)'(0), select_ff};
   assign last_of_scan    = last_ff;

endmodule

// ===== rtl/core/seven_segment_scan_serializer.sv =====
`timescale 1ns / 1ps
// Top level of the seven-segment scan serializer: controller plus datapath.
// Depends on segscan_pkg, segscan_if, segscan_ctrl and segscan_dp.
//
//   channel  direction  carries                                   accepted when
//   req_if   in         mode, code_d0..3, dot_d0..3               valid && ready
//   rsp_if   out        segment_pattern, digit_select,            valid && ready
//                       serial_word, last_of_scan
//   csr_if   in         index, data (register write)              valid && ready
//
// A write transaction (modes 1 to 5, and ignored modes 6, 7) is applied in idle.
// A tick gives min(DIGIT_COUNT, 4) results: the first is valid after ST_LOAD, in
// ST_SEND, then one per cycle while rsp ready holds; the digit index counter in
// the datapath steps the scan. req ready returns the cycle after the last result
// is taken. Reset is synchronous: codes blank, dots off, registers at their reset
// values. A stall on rsp holds the result register and the index.
module seven_segment_scan_serializer #(
   parameter int DIGIT_COUNT = segscan_pkg::DIGIT_COUNT_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   segscan_req_if.sink   req_if,
   segscan_rsp_if.source rsp_if,
   segscan_csr_if.sink   csr_if
);

   localparam int SCAN_LEN = (DIGIT_COUNT < segscan_pkg::STORE_DIGITS) ?
                             DIGIT_COUNT : segscan_pkg::STORE_DIGITS;

   segscan_pkg::cmd_type    cmd;
   segscan_pkg::status_type status;

   logic [segscan_pkg::STORE_DIGITS-1:0][segscan_pkg::CODE_W-1:0] req_codes;
   logic [segscan_pkg::STORE_DIGITS-1:0]                         req_dots;

   assign req_codes = {req_if.code_d3, req_if.code_d2, req_if.code_d1, req_if.code_d0};
   assign req_dots  = {req_if.dot_d3, req_if.dot_d2, req_if.dot_d1, req_if.dot_d0};

   // Registers are always writable
   assign csr_if.ready = 1'b1;

   segscan_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_mode  (req_if.mode),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .status    (status)
   );

   segscan_dp #(
      .SCAN_LEN (SCAN_LEN)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_mode        (req_if.mode),
      .req_codes       (req_codes),
      .req_dots        (req_dots),
      .csr_write       (csr_if.valid),
      .csr_index       (csr_if.index),
      .csr_data        (csr_if.data),
      .segment_pattern (rsp_if.segment_pattern),
      .digit_select    (rsp_if.digit_select),
      .serial_word     (rsp_if.serial_word),
      .last_of_scan    (rsp_if.last_of_scan)
   );

   // No new transaction is taken while a result is pending
   a_no_req_during_rsp: assert property (
      @(posedge clock) disable iff (reset) rsp_if.valid |-> !req_if.ready
   ) else $error("request accepted while a result is pending");

   // A tick shows its first result once the controller has passed through ST_LOAD
   a_tick_first_rsp: assert property (
      @(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready &&
       segscan_pkg::mode_type'(req_if.mode) == segscan_pkg::MODE_TICK)
      |=> ##1 rsp_if.valid
   ) else $error("tick did not produce a result in time");

   // A write transaction leaves the block idle
   a_write_stays_idle: assert property (
      @(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready &&
       segscan_pkg::mode_type'(req_if.mode) != segscan_pkg::MODE_TICK)
      |=> (req_if.ready && !rsp_if.valid)
   ) else $error("write transaction started a scan");

   // Scan ends once the last digit is taken
   a_last_ends_scan: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready && rsp_if.last_of_scan) |=> !rsp_if.valid
   ) else $error("results continued after the last digit");

   // Exactly one digit enabled on every result
   a_select_onehot: assert property (
      @(posedge clock) disable iff (reset)
      rsp_if.valid |-> $onehot(rsp_if.digit_select)
   ) else $error("digit select is not one-hot");

endmodule
